// ----- rtl/core/fbd_pkg.sv -----
package fbd_pkg;

    // Screen geometry
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;
    localparam int PAGE_COUNT    = (SCREEN_HEIGHT + 7) / 8;
    localparam int STORE_BYTES   = SCREEN_WIDTH * PAGE_COUNT;
    localparam int ADDR_W        = $clog2(STORE_BYTES);
    localparam int CNT_W         = $clog2(STORE_BYTES + 1);

    // Transaction kinds
    localparam logic [2:0] KIND_PIXEL = 3'd0;
    localparam logic [2:0] KIND_HRUN  = 3'd1;
    localparam logic [2:0] KIND_VRUN  = 3'd2;
    localparam logic [2:0] KIND_CLEAR = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Colors
    localparam logic [1:0] COLOR_CLEAR  = 2'd0;
    localparam logic [1:0] COLOR_SET    = 2'd1;
    localparam logic [1:0] COLOR_TOGGLE = 2'd2;
    localparam logic [1:0] COLOR_NONE   = 2'd3;

    typedef enum logic [2:0] {
        S_CLR,
        S_IDLE,
        S_SETUP,
        S_RMW_RD,
        S_RMW_WR,
        S_RD,
        S_RD_WAIT
    } t_state;

    // Frame store port request
    typedef struct packed {
        logic              rd_en;
        logic              wr_en;
        logic [ADDR_W-1:0] addr;
        logic [7:0]        wr_data;
    } t_mem_req;

    // Apply a pixel mask to one stored byte
    function automatic logic [7:0] apply_mask(input logic [7:0] data,
                                              input logic [7:0] mask,
                                              input logic [1:0] color);
        logic [7:0] res;
        case (color)
            COLOR_CLEAR:  res = data & ~mask;
            COLOR_SET:    res = data | mask;
            COLOR_TOGGLE: res = data ^ mask;
            default:      res = data;
        endcase
        return res;
    endfunction

endpackage

// ----- rtl/core/fbd_req_if.sv -----
interface fbd_req_if;
    logic              valid;
    logic              ready;
    logic [2:0]        kind;
    logic signed [8:0] x_coord;
    logic signed [8:0] y_coord;
    logic signed [8:0] run_length;
    logic [1:0]        draw_color;
    logic [9:0]        byte_index;

    modport source (
        output valid, kind, x_coord, y_coord, run_length, draw_color, byte_index,
        input  ready
    );
    modport sink (
        input  valid, kind, x_coord, y_coord, run_length, draw_color, byte_index,
        output ready
    );
endinterface

// ----- rtl/core/fbd_rsp_if.sv -----
interface fbd_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;

    modport source (
        output valid, byte_value,
        input  ready
    );
    modport sink (
        input  valid, byte_value,
        output ready
    );
endinterface

// ----- rtl/core/page_framebuffer_line_draw.sv -----
// Channel  | Dir | Payload                                                | Note
// i_req    | in  | kind, x_coord, y_coord, run_length, draw_color,        | draw or read
//          |     | byte_index                                             |
// o_rsp    | out | byte_value                                             | reads only
//
// A read waits while the result slot is full; a clear writes zero to all
// STORE_BYTES bytes of the store.
// Each touched byte is a read-modify-write through the single frame store port.
// Reset: a clearing pass zeroes all STORE_BYTES bytes of the store; i_req
// is not ready until it ends.
// Stalls: the result register holds a read byte until taken; new draws are
// accepted meanwhile, a following read waits for the slot.
module page_framebuffer_line_draw (
    input  logic     i_clk,
    input  logic     i_rst_n,
    fbd_req_if.sink  i_req,
    fbd_rsp_if.source o_rsp
);

    fbd_pkg::t_mem_req mem_req;
    logic [7:0]        rd_data;
    logic              rd_done;
    logic              rd_zero;
    logic              slot_free;
    logic              r_rsp_valid;
    logic [7:0]        r_rsp_byte;

    assign slot_free = !r_rsp_valid || o_rsp.ready;

    fbd_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_rd_data   (rd_data),
        .i_slot_free (slot_free),
        .o_mem       (mem_req),
        .o_rd_done   (rd_done),
        .o_rd_zero   (rd_zero)
    );

    fbd_store u_store (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_data (rd_data)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (rd_done) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_done) begin
            r_rsp_byte <= rd_zero ? 8'h00 : rd_data;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.byte_value = r_rsp_byte;

endmodule

// ----- rtl/core/fbd_store.sv -----
module fbd_store (
    input  logic                        i_clk,
    input  fbd_pkg::t_mem_req           i_req,
    output logic [7:0]                  o_rd_data
);

    logic [7:0] r_mem [fbd_pkg::STORE_BYTES];
    logic [7:0] r_rd_data;

    // Single port frame store, registered read
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/core/fbd_seq.sv -----
module fbd_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    fbd_req_if.sink           i_req,
    input  logic [7:0]        i_rd_data,
    input  logic              i_slot_free,
    output fbd_pkg::t_mem_req o_mem,
    output logic              o_rd_done,
    output logic              o_rd_zero
);

    localparam logic signed [10:0] W_S = 11'(fbd_pkg::SCREEN_WIDTH);
    localparam logic signed [10:0] H_S = 11'(fbd_pkg::SCREEN_HEIGHT);

    fbd_pkg::t_state r_state, n_state;

    // Captured transaction
    logic [2:0]        r_kind;
    logic signed [8:0] r_x, r_y, r_len;
    logic [1:0]        r_color;
    logic [9:0]        r_index;

    // Walk state
    logic [fbd_pkg::ADDR_W-1:0] r_addr, n_addr;
    logic [fbd_pkg::ADDR_W-1:0] r_step, n_step;
    logic [fbd_pkg::CNT_W-1:0]  r_cnt, n_cnt;
    logic                       r_first, n_first;
    logic [7:0]                 r_fmask, n_fmask;
    logic [7:0]                 r_lmask, n_lmask;
    logic [7:0]                 r_mmask, n_mmask;
    logic                       r_zero, n_zero;

    // Clip arithmetic
    logic signed [10:0] x_s, y_s, len_s;
    logic signed [10:0] h_start, h_end_raw, h_end, h_cnt;
    logic signed [10:0] v_start, v_end_raw, v_end, v_last;
    logic [7:0]         v_cnt;
    logic               h_ok, v_ok;
    logic [fbd_pkg::ADDR_W-1:0] addr_step;
    logic [7:0]         byte_mask;

    assign x_s   = $signed({{2{r_x[8]}}, r_x});
    assign y_s   = $signed({{2{r_y[8]}}, r_y});
    assign len_s = (r_kind == fbd_pkg::KIND_PIXEL) ? 11'sd1
                                                   : $signed({{2{r_len[8]}}, r_len});

    // Horizontal run clipping
    assign h_start   = (x_s < 0) ? 11'sd0 : x_s;
    assign h_end_raw = x_s + len_s;
    assign h_end     = (h_end_raw > W_S) ? W_S : h_end_raw;
    assign h_cnt     = h_end - h_start;
    assign h_ok      = (y_s >= 0) && (y_s < H_S) && (h_end > h_start);

    // Vertical run clipping; a pixel is a vertical run of one
    assign v_start   = (y_s < 0) ? 11'sd0 : y_s;
    assign v_end_raw = y_s + len_s;
    assign v_end     = (v_end_raw > H_S) ? H_S : v_end_raw;
    assign v_last    = v_end - 11'sd1;
    assign v_cnt     = v_last[10:3] - v_start[10:3] + 8'd1;
    assign v_ok      = (x_s >= 0) && (x_s < W_S) && (v_end > v_start);

    // Shared address and count unit
    assign addr_step = r_addr + r_step;
    assign byte_mask = r_mmask & (r_first ? r_fmask : 8'hFF)
                     & ((r_cnt == fbd_pkg::CNT_W'(1)) ? r_lmask : 8'hFF);

    assign i_req.ready = (r_state == fbd_pkg::S_IDLE);

    // Capture transaction
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_kind  <= i_req.kind;
            r_x     <= i_req.x_coord;
            r_y     <= i_req.y_coord;
            r_len   <= i_req.run_length;
            r_color <= i_req.draw_color;
            r_index <= i_req.byte_index;
        end
    end

    // State and walk registers; reset starts the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fbd_pkg::S_CLR;
            r_addr  <= '0;
            r_step  <= fbd_pkg::ADDR_W'(1);
            r_cnt   <= fbd_pkg::CNT_W'(fbd_pkg::STORE_BYTES);
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_step  <= n_step;
            r_cnt   <= n_cnt;
            r_first <= n_first;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fmask <= n_fmask;
        r_lmask <= n_lmask;
        r_mmask <= n_mmask;
        r_zero  <= n_zero;
    end

    // Next state and memory control
    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        n_step    = r_step;
        n_cnt     = r_cnt;
        n_first   = r_first;
        n_fmask   = r_fmask;
        n_lmask   = r_lmask;
        n_mmask   = r_mmask;
        n_zero    = r_zero;
        o_mem     = '0;
        o_mem.addr = r_addr;
        o_rd_done = 1'b0;

        case (r_state)
            fbd_pkg::S_CLR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_data = 8'h00;
                n_addr        = addr_step;
                n_cnt         = r_cnt - fbd_pkg::CNT_W'(1);
                if (r_cnt == fbd_pkg::CNT_W'(1)) begin
                    n_state = fbd_pkg::S_IDLE;
                end
            end
            fbd_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_state = fbd_pkg::S_SETUP;
                end
            end
            fbd_pkg::S_SETUP: begin
                n_first = 1'b1;
                n_state = fbd_pkg::S_IDLE;
                case (r_kind)
                    fbd_pkg::KIND_PIXEL, fbd_pkg::KIND_VRUN: begin
                        n_addr  = fbd_pkg::ADDR_W'(int'(v_start[10:3]) * fbd_pkg::SCREEN_WIDTH
                                                   + int'(x_s[8:0]));
                        n_step  = fbd_pkg::ADDR_W'(fbd_pkg::SCREEN_WIDTH);
                        n_cnt   = fbd_pkg::CNT_W'(v_cnt);
                        n_fmask = 8'hFF << v_start[2:0];
                        n_lmask = 8'hFF >> (3'd7 - v_last[2:0]);
                        n_mmask = 8'hFF;
                        if (v_ok && (r_color != fbd_pkg::COLOR_NONE)) begin
                            n_state = fbd_pkg::S_RMW_RD;
                        end
                    end
                    fbd_pkg::KIND_HRUN: begin
                        n_addr  = fbd_pkg::ADDR_W'(int'(y_s[10:3]) * fbd_pkg::SCREEN_WIDTH
                                                   + int'(h_start[9:0]));
                        n_step  = fbd_pkg::ADDR_W'(1);
                        n_cnt   = fbd_pkg::CNT_W'(h_cnt[9:0]);
                        n_fmask = 8'hFF;
                        n_lmask = 8'hFF;
                        n_mmask = 8'h01 << y_s[2:0];
                        if (h_ok && (r_color != fbd_pkg::COLOR_NONE)) begin
                            n_state = fbd_pkg::S_RMW_RD;
                        end
                    end
                    fbd_pkg::KIND_CLEAR: begin
                        n_addr  = '0;
                        n_step  = fbd_pkg::ADDR_W'(1);
                        n_cnt   = fbd_pkg::CNT_W'(fbd_pkg::STORE_BYTES);
                        n_state = fbd_pkg::S_CLR;
                    end
                    fbd_pkg::KIND_READ: begin
                        n_addr  = fbd_pkg::ADDR_W'(r_index);
                        n_zero  = (int'(r_index) >= fbd_pkg::STORE_BYTES);
                        n_state = fbd_pkg::S_RD;
                    end
                    default: begin
                        n_state = fbd_pkg::S_IDLE;
                    end
                endcase
            end
            fbd_pkg::S_RMW_RD: begin
                o_mem.rd_en = 1'b1;
                n_state     = fbd_pkg::S_RMW_WR;
            end
            fbd_pkg::S_RMW_WR: begin
                o_mem.wr_en   = 1'b1;
                o_mem.wr_data = fbd_pkg::apply_mask(i_rd_data, byte_mask, r_color);
                n_addr        = addr_step;
                n_cnt         = r_cnt - fbd_pkg::CNT_W'(1);
                n_first       = 1'b0;
                if (r_cnt == fbd_pkg::CNT_W'(1)) begin
                    n_state = fbd_pkg::S_IDLE;
                end else begin
                    n_state = fbd_pkg::S_RMW_RD;
                end
            end
            fbd_pkg::S_RD: begin
                o_mem.rd_en = 1'b1;
                n_state     = fbd_pkg::S_RD_WAIT;
            end
            fbd_pkg::S_RD_WAIT: begin
                if (i_slot_free) begin
                    o_rd_done = 1'b1;
                    n_state   = fbd_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = fbd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_rd_zero = r_zero;

endmodule
